@@ src/cdcb_pkg.sv @@
// Shared constants and types for the complex domain color blender.
// No dependencies; imported by the top level and its port checker.
package cdcb_pkg;

  localparam int COLOR_BITS_DEF      = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // sqrt(3)/2 in Q0.16, and the 2^16 trig scale as a shift
  localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
  localparam int          TRIG_SHIFT     = 16;

  typedef enum logic {
    MODE_HUE  = 1'b0,
    MODE_GRAY = 1'b1
  } color_mode_e;

endpackage

@@ src/complex_domain_color_blend.sv @@
// Domain coloring pixel blender: hue from arg(z) scaled by |z|/(|z|+1),
// or gray 1/(1+|z|), added to the current pixel with saturation.
// Depends on cdcb_pkg.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries z_real_i, z_imag_i
//   (signed fixed point, COORD_FRAC_BITS fraction bits) and the current
//   pixel prev_red_i / prev_green_i / prev_blue_i. Output channel
//   (out_valid_o / out_ready_i) carries out_red_o / out_green_o / out_blue_o.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes color_mode_i;
//   it is always ready. Write it only while the pipeline is empty.
// Throughput: one transaction per cycle while the output is not stalled.
// Depth: 71 register stages. Most of the depth is the 32 stage integer
//   square root and the 32 stage per-channel restoring division, one
//   result bit per stage.
// Reset: all valid bits clear, color_mode returns to hue mode.
// Stall: when the output holds a transaction that is not taken, the whole
//   pipeline freezes and in_ready_o drops; nothing is lost or repeated.
module complex_domain_color_blend import cdcb_pkg::*; #(
  parameter int COLOR_BITS      = COLOR_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  color_mode_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    z_real_i,
  input  logic signed [31:0]    z_imag_i,
  input  logic [COLOR_BITS-1:0] prev_red_i,
  input  logic [COLOR_BITS-1:0] prev_green_i,
  input  logic [COLOR_BITS-1:0] prev_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COLOR_BITS-1:0] out_red_o,
  output logic [COLOR_BITS-1:0] out_green_o,
  output logic [COLOR_BITS-1:0] out_blue_o
);

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int REM_W      = 34;
  localparam int M_W        = 32;
  localparam int DEN_W      = M_W + 1 + TRIG_SHIFT + 1;
  localparam int NUM_W      = DEN_W + 2;
  localparam int IMS_W      = 32 + 17;
  localparam int PROD_W     = DIV_STEPS + COLOR_BITS;
  // stage indexes
  localparam int S_ROOT   = 3;
  localparam int S_NUMER  = S_ROOT + ROOT_STEPS;
  localparam int S_CLASS  = S_NUMER + 1;
  localparam int S_DIV    = S_CLASS + 1;
  localparam int S_MULT   = S_DIV + DIV_STEPS;
  localparam int NSTAGE   = S_MULT + 2;

  localparam logic [M_W:0]            ONE  = (M_W + 1)'(1) << COORD_FRAC_BITS;
  localparam logic [COLOR_BITS-1:0]   FULL = {COLOR_BITS{1'b1}};
  localparam logic [PROD_W:0]         RND  = (PROD_W + 1)'(1) << (DIV_STEPS - 1);

  typedef struct packed {
    logic                          mode;
    logic signed [31:0]            re;
    logic signed [IMS_W-1:0]       ims;
    logic [2:0][COLOR_BITS-1:0]    prev;
  } ctx_t;

  // ---------------------------------------------------------------- control
  logic              adv;
  logic [NSTAGE-1:0] vld_q, vld_d;
  color_mode_e       mode_q;

  assign adv         = !vld_q[NSTAGE-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NSTAGE-1];
  assign vld_d       = {vld_q[NSTAGE-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mode_q <= MODE_HUE;
    end else begin
      if (adv) vld_q <= vld_d;
      if (cfg_valid_i) mode_q <= color_mode_e'(color_mode_i);
    end
  end

  // ------------------------------------------------- input, squares, sum
  logic signed [31:0] re0_q, im0_q;
  ctx_t               ctx0_q, ctx1_q;
  logic [31:0]        are_d, aim_d;
  logic [63:0]        sqr_d, sqi_d, sqr1_q, sqi1_q;
  logic signed [IMS_W-1:0] im_ext_d, k_ext_d, ims_d;

  assign are_d    = re0_q[31] ? 32'(-re0_q) : 32'(re0_q);
  assign aim_d    = im0_q[31] ? 32'(-im0_q) : 32'(im0_q);
  assign sqr_d    = are_d * are_d;
  assign sqi_d    = aim_d * aim_d;
  assign im_ext_d = IMS_W'(im0_q);
  assign k_ext_d  = $signed(IMS_W'(SQRT3_HALF_Q16));
  assign ims_d    = im_ext_d * k_ext_d;

  // sqrt pipeline arrays: index 0 feeds the first root step
  logic [63:0]        rv_q  [0:ROOT_STEPS];
  logic [REM_W-1:0]   rr_q  [0:ROOT_STEPS];
  logic [M_W-1:0]     rq_q  [0:ROOT_STEPS];
  ctx_t               rc_q  [0:ROOT_STEPS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re0_q  <= z_real_i;
      im0_q  <= z_imag_i;
      ctx0_q <= '{mode: mode_q, re: z_real_i, ims: '0,
                  prev: {prev_blue_i, prev_green_i, prev_red_i}};
      sqr1_q <= sqr_d;
      sqi1_q <= sqi_d;
      ctx1_q <= '{mode: ctx0_q.mode, re: ctx0_q.re, ims: ims_d, prev: ctx0_q.prev};
      rv_q[0] <= sqr1_q + sqi1_q;
      rr_q[0] <= '0;
      rq_q[0] <= '0;
      rc_q[0] <= ctx1_q;
    end
  end

  // ----------------------------------------------- integer square root
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    logic [REM_W+1:0] pre_d, trial_d;
    logic             ge_d;
    assign pre_d   = {rr_q[k], rv_q[k][63:62]};
    assign trial_d = (REM_W + 2)'({rq_q[k], 2'b01});
    assign ge_d    = pre_d >= trial_d;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rv_q[k+1] <= {rv_q[k][61:0], 2'b00};
        rr_q[k+1] <= ge_d ? REM_W'(pre_d - trial_d) : REM_W'(pre_d);
        rq_q[k+1] <= {rq_q[k][M_W-2:0], ge_d};
        rc_q[k+1] <= rc_q[k];
      end
    end
  end

  // ------------------------------------------------ numerators, divisor
  logic [M_W-1:0]          m_d;
  logic [M_W:0]            mp_d;
  logic signed [NUM_W-1:0] ms_d, re16_d, reh_d, imsx_d, gray_d;
  logic signed [NUM_W-1:0] num_q [0:2];
  logic [DEN_W-1:0]        den_q, den2_q;
  logic [2:0][COLOR_BITS-1:0] prev_n_q;

  assign m_d    = rq_q[ROOT_STEPS];
  assign mp_d   = (M_W + 1)'(m_d) + ONE;
  assign ms_d   = $signed(NUM_W'({m_d, {TRIG_SHIFT{1'b0}}}));
  assign re16_d = NUM_W'(rc_q[ROOT_STEPS].re) <<< TRIG_SHIFT;
  assign reh_d  = NUM_W'(rc_q[ROOT_STEPS].re) <<< (TRIG_SHIFT - 1);
  assign imsx_d = NUM_W'(rc_q[ROOT_STEPS].ims);
  assign gray_d = $signed(NUM_W'({ONE, {(TRIG_SHIFT + 1){1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q    <= {mp_d, {(TRIG_SHIFT + 1){1'b0}}};
      prev_n_q <= rc_q[ROOT_STEPS].prev;
      if (rc_q[ROOT_STEPS].mode == MODE_GRAY) begin
        num_q[0] <= gray_d;
        num_q[1] <= gray_d;
        num_q[2] <= gray_d;
      end else begin
        num_q[0] <= ms_d + re16_d;
        num_q[1] <= ms_d - reh_d - imsx_d;
        num_q[2] <= ms_d - reh_d + imsx_d;
      end
    end
  end

  // ---------------------------------------- classify, restoring division
  logic [DEN_W-1:0]           dn_q   [0:DIV_STEPS][0:2];
  logic [DIV_STEPS-1:0]       dq_q   [0:DIV_STEPS][0:2];
  logic [2:0]                 zero_q [0:DIV_STEPS];
  logic [2:0]                 full_q [0:DIV_STEPS];
  logic [DEN_W-1:0]           dd_q   [0:DIV_STEPS];
  logic [2:0][COLOR_BITS-1:0] dp_q   [0:DIV_STEPS];

  for (genvar l = 0; l < 3; l++) begin : g_class
    logic zero_d;
    assign zero_d = num_q[l][NUM_W-1] || (num_q[l] == '0);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        zero_q[0][l] <= zero_d;
        full_q[0][l] <= !zero_d && ($unsigned(num_q[l]) >= NUM_W'(den_q));
        dn_q[0][l]   <= DEN_W'(num_q[l]);
        dq_q[0][l]   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= den_q;
      dp_q[0] <= prev_n_q;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DEN_W:0] n2_d;
      logic           ge_d;
      assign n2_d = {dn_q[j][l], 1'b0};
      assign ge_d = n2_d >= {1'b0, dd_q[j]};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dn_q[j+1][l] <= ge_d ? DEN_W'(n2_d - {1'b0, dd_q[j]}) : DEN_W'(n2_d);
          dq_q[j+1][l] <= {dq_q[j][l][DIV_STEPS-2:0], ge_d};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[j+1]   <= dd_q[j];
        dp_q[j+1]   <= dp_q[j];
        zero_q[j+1] <= zero_q[j];
        full_q[j+1] <= full_q[j];
      end
    end
  end

  // ------------------------------------------- scale, round, blend
  logic [PROD_W-1:0]          prod_q [0:2];
  logic [2:0]                 zero_m_q, full_m_q;
  logic [2:0][COLOR_BITS-1:0] prev_m_q;
  logic [COLOR_BITS-1:0]      out_q  [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [PROD_W:0]       rnd_d;
    logic [COLOR_BITS-1:0] ch_d;
    logic [COLOR_BITS:0]   sum_d;
    assign rnd_d = (PROD_W + 1)'(prod_q[l]) + RND;
    always_comb begin
      if (zero_m_q[l])      ch_d = '0;
      else if (full_m_q[l]) ch_d = FULL;
      else                  ch_d = rnd_d[DIV_STEPS +: COLOR_BITS];
    end
    assign sum_d = (COLOR_BITS + 1)'(prev_m_q[l]) + (COLOR_BITS + 1)'(ch_d);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[l] <= dq_q[DIV_STEPS][l] * FULL;
        out_q[l]  <= sum_d[COLOR_BITS] ? FULL : sum_d[COLOR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_m_q <= zero_q[DIV_STEPS];
      full_m_q <= full_q[DIV_STEPS];
      prev_m_q <= dp_q[DIV_STEPS];
    end
  end

  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

@@ src/cdcb_checker.sv @@
// Port-level checker for complex_domain_color_blend, bound to the top level.
// Depends on cdcb_pkg.
module cdcb_checker import cdcb_pkg::*; #(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_ready_o,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COLOR_BITS-1:0] out_red_o,
  input logic [COLOR_BITS-1:0] out_green_o,
  input logic [COLOR_BITS-1:0] out_blue_o
);

  // a stalled output keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_red_o) && $stable(out_green_o)
                                    && $stable(out_blue_o))
    else $error("output payload changed while stalled");

  // backpressure reaches the input in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // no result appears right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind complex_domain_color_blend cdcb_checker #(.COLOR_BITS(COLOR_BITS)) u_cdcb_checker (.*);

@@ tb/complex_domain_color_blend_tb.sv @@
// Self-checking testbench for complex_domain_color_blend: drives z and pixel
// transactions with random idling, predicts each blended pixel, compares in order.
// Depends on cdcb_pkg and the complex_domain_color_blend RTL.
`timescale 1ns / 100ps

module complex_domain_color_blend_tb;
  import cdcb_pkg::*;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int PIPE_LAT = 71;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [CB-1:0] r, g, b;
  } pixel_in_t;

  typedef struct packed {
    logic [CB-1:0] r, g, b;
  } pixel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic color_mode_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] z_real_i = '0;
  logic signed [31:0] z_imag_i = '0;
  logic [CB-1:0] prev_red_i = '0, prev_green_i = '0, prev_blue_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CB-1:0] out_red_o, out_green_o, out_blue_o;

  always #1 clk_i = ~clk_i;

  complex_domain_color_blend u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .color_mode_i,
    .in_valid_i, .in_ready_o, .z_real_i, .z_imag_i,
    .prev_red_i, .prev_green_i, .prev_blue_i,
    .out_valid_o, .out_ready_i, .out_red_o, .out_green_o, .out_blue_o
  );

  color_mode_e mode_model = MODE_HUE;
  pixel_in_t   pixel_queue[$];
  pixel_out_t  blend_expected[$];
  int          mismatch_cnt = 0;
  int          blend_cnt = 0;
  longint      cycle_cnt = 0;
  bit          calm = 0;      // no idling stretch
  bit          sender_hold = 0;
  bit          hold_req = 0;
  bit          receiver_hold = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [CB-1:0] ratio_channel(longint signed num_s,
                                                  longint unsigned den);
    longint unsigned num, q, full;
    full = (64'd1 << CB) - 1;
    q = 0;
    if (num_s <= 0) return '0;
    num = num_s;
    if (num >= den) return full[CB-1:0];
    for (int i = 0; i < 32; i++) begin
      num <<= 1;
      q <<= 1;
      if (num >= den) begin
        num -= den;
        q |= 1;
      end
    end
    return CB'((q * full + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic [CB-1:0] sat_sum(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] s;
    s = a + b;
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  function automatic pixel_out_t blend_pixel(pixel_in_t p);
    longint signed re, im, ms;
    longint unsigned are, aim, mag, den, one;
    logic [CB-1:0] cr, cg, cb;
    pixel_out_t o;
    re = p.re;
    im = p.im;
    are = re < 0 ? -re : re;
    aim = im < 0 ? -im : im;
    mag = int_sqrt(are * are + aim * aim);
    one = 64'd1 << FB;
    if (mode_model == MODE_GRAY) begin
      cr = ratio_channel(one, mag + one);
      cg = cr;
      cb = cr;
    end else begin
      ms = mag << TRIG_SHIFT;
      den = 2 * (mag + one) << TRIG_SHIFT;
      cr = ratio_channel(ms + (re <<< TRIG_SHIFT), den);
      cg = ratio_channel(ms - re * 32768 - im * longint'(SQRT3_HALF_Q16), den);
      cb = ratio_channel(ms - re * 32768 + im * longint'(SQRT3_HALF_Q16), den);
    end
    o.r = sat_sum(p.r, cr);
    o.g = sat_sum(p.g, cg);
    o.b = sat_sum(p.b, cb);
    return o;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      3: return $signed($urandom_range(0, 64)) - 32;
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_color();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return CB'($urandom_range(0, 255));
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic push_pixel(logic signed [31:0] re, logic signed [31:0] im,
                            logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    pixel_in_t p;
    p = '{re, im, r, g, b};
    pixel_queue.insert(pixel_queue.size(), p);
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid_i || blend_expected.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_mode(color_mode_e m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    color_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_model = m;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) blend_expected.insert(blend_expected.size(),
        blend_pixel('{z_real_i, z_imag_i, prev_red_i, prev_green_i, prev_blue_i}));
    if (!in_valid_i || in_ready_o) begin
      if (pixel_queue.size() != 0 && !sender_hold && rst_ni &&
          (calm || $urandom_range(0, 99) >= 23)) begin
        pixel_in_t p;
        p = pixel_queue.pop_front();
        in_valid_i <= 1'b1;
        z_real_i <= p.re;
        z_imag_i <= p.im;
        prev_red_i <= p.r;
        prev_green_i <= p.g;
        prev_blue_i <= p.b;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver stall, counted here once requested
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    receiver_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  // monitor and output ready
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (out_valid_o && out_ready_i) begin
      if (blend_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction %h %h %h",
                                         out_red_o, out_green_o, out_blue_o);
      end else begin
        pixel_out_t e;
        e = blend_expected.pop_front();
        blend_cnt++;
        if (e.r !== out_red_o || e.g !== out_green_o || e.b !== out_blue_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch #%0d: exp r=%h g=%h b=%h, got r=%h g=%h b=%h",
                     blend_cnt, e.r, e.g, e.b, out_red_o, out_green_o, out_blue_o);
        end
      end
    end
    out_ready_i <= receiver_hold ? 1'b0 : (calm || $urandom_range(0, 99) >= 23);
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      color_mode_e m;
      m = (ph % 2) ? MODE_GRAY : MODE_HUE;
      if (ph > 0) write_mode(m);
      if (ph == 0) write_mode(MODE_HUE);
      // directed corners: zero, extremes, axes, saturation
      push_pixel(0, 0, 0, 0, 0);
      push_pixel(0, 0, '1, '1, '1);
      push_pixel(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
      push_pixel(32'sh80000000, 32'sh80000000, '1, 0, 16'h8000);
      push_pixel(32'sh80000000, 32'sh7fffffff, 16'h5555, 16'haaaa, 0);
      push_pixel(1 << FB, 0, 0, 0, 0);
      push_pixel(-(1 << FB), 0, 0, 0, 0);
      push_pixel(0, 1 << FB, 0, 0, 0);
      push_pixel(0, -(1 << FB), 0, 0, 0);
      push_pixel(1, 0, 0, 0, 0);
      push_pixel(-1, 1, 0, 0, 0);
      push_pixel(-2, 3, 16'hfff0, 16'hfff0, 16'hfff0);
      push_pixel(32'sh40000000, -32'sh40000000, 16'hc000, 16'hc000, 16'hc000);
      calm = (ph == 2);
      for (int i = 0; i < 225; i++)
        push_pixel(rand_coord(), rand_coord(), rand_color(), rand_color(), rand_color());
      if (ph == 1) begin
        // long receiver stall so the pipeline fills and backs up
        while (pixel_queue.size() > 150) @(posedge clk_i);
        hold_req = 1;
        @(posedge clk_i);
      end
      if (ph == 3) begin
        // sender waits for the pipeline to empty, then resumes
        while (pixel_queue.size() > 100) @(posedge clk_i);
        sender_hold = 1;
        while (in_valid_i || blend_expected.size() != 0) @(posedge clk_i);
        sender_hold = 0;
      end
      wait_drained();
      calm = 0;
    end
    $display("covered %0d blended pixels across hue and gray modes, incl. stalls",
             blend_cnt);
    if (mismatch_cnt == 0 && blend_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d left over", mismatch_cnt, blend_expected.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
